FILE: src/tsccm_pkg.sv
// Shared types and constants for the transport stream continuity counter monitor.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsccm_pkg;

  // Field widths; PID and CC widths are fixed by the transport packet header
  localparam int PidW = 13;
  localparam int CcW  = 4;
  localparam int CntW = 32;
  localparam int EvW  = 32;

  // Null packet PID; also the "monitor all PIDs" filter setting
  localparam logic [PidW-1:0] NullPid = 13'h1FFF;
  localparam logic [CntW-1:0] CntMax  = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFilterPid = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgEventCode = 1'd1;
  localparam int CfgDataW = 32;

  // Queue between classifier and checker
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef struct packed {
    logic [PidW-1:0] pid;
    logic [CcW-1:0]  cont_count;
  } pkt_t;

  typedef struct packed {
    logic            skipped;
    logic            first_seen;
    logic            cc_error;
    logic [CcW-1:0]  expected_cc;
    logic            event_fire;
    logic [EvW-1:0]  event_value;
    logic [CntW-1:0] packet_total;
    logic [CntW-1:0] error_total;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Classified packet: table slot is pid - quo * PID_SPACE
  typedef struct packed {
    logic [PidW-1:0] pid;
    logic [PidW-1:0] quo;
    logic [CcW-1:0]  cont_count;
    logic            skip;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: src/tsccm_front.sv
// Front end: accepts packet headers, applies null/filter test and starts the
// table slot reduction. Depends on tsccm_pkg.
`default_nettype none

module tsccm_front #(
  parameter int PID_SPACE = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsccm_pkg::cfg_wr_t cfg,
  input  wire logic              pkt_valid,
  output logic                   pkt_stall,
  input  wire tsccm_pkg::pkt_t   pkt,
  input  wire logic              q_full,
  input  wire logic              clearing,
  output logic                   q_push,
  output tsccm_pkg::q_entry_t    q_entry
);
  import tsccm_pkg::*;

  localparam int IdxW       = (PID_SPACE > 1) ? $clog2(PID_SPACE) : 1;
  localparam int RecipShift = PidW + IdxW;
  localparam int RecipW     = PidW + 2;
  localparam int ProdW      = PidW + RecipW;
  localparam int Recip      = ((1 << RecipShift) + PID_SPACE - 1) / PID_SPACE;

  logic [PidW-1:0]  filter_pid;
  logic [ProdW-1:0] prod;
  logic             skip;

  // Hold the filter PID register
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_pid <= NullPid;
    end else if (cfg.we && cfg.index == CfgFilterPid) begin
      filter_pid <= cfg.data[PidW-1:0];
    end
  end

  // Mark null packets and, with a filter set, every other PID as skipped
  always_comb begin
    skip = (pkt.pid == NullPid) || (filter_pid != NullPid && pkt.pid != filter_pid);
  end

  // Quotient of pid / PID_SPACE by reciprocal multiplication (exact for 13-bit pid)
  always_comb begin
    prod = ProdW'(pkt.pid) * ProdW'(Recip);
  end

  assign pkt_stall          = q_full || clearing;
  assign q_push             = pkt_valid && !pkt_stall;
  assign q_entry.pid        = pkt.pid;
  assign q_entry.quo        = PidW'(prod >> RecipShift);
  assign q_entry.cont_count = pkt.cont_count;
  assign q_entry.skip       = skip;

endmodule

`default_nettype wire

FILE: src/tsccm_queue.sv
// Short FIFO of classified transactions between front end and checker.
// Depends on tsccm_pkg.
`default_nettype none

module tsccm_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tsccm_pkg::q_entry_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output tsccm_pkg::q_entry_t     head
);
  import tsccm_pkg::*;

  q_entry_t         slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: src/tsccm_back.sv
// Checker: per-slot seen/last-CC memory, counters, event register and result
// register. Depends on tsccm_pkg.
`default_nettype none

module tsccm_back #(
  parameter int PID_SPACE = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tsccm_pkg::cfg_wr_t  cfg,
  input  wire logic               head_valid,
  input  wire tsccm_pkg::q_entry_t head,
  output logic                    pop,
  output logic                    clearing,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output tsccm_pkg::res_t         res
);
  import tsccm_pkg::*;

  localparam int IdxW = (PID_SPACE > 1) ? $clog2(PID_SPACE) : 1;
  localparam int EntW = CcW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [IdxW-1:0]   clr_idx;
  logic [EvW-1:0]    event_code;
  logic [CntW-1:0]   pkt_count;
  logic [CntW-1:0]   err_count;

  // Current transaction
  logic [IdxW-1:0]   cur_slot;
  logic [CcW-1:0]    cur_cc;
  logic              cur_skip;

  // Table memory: {seen, last CC}
  logic [EntW-1:0]   table_mem [PID_SPACE];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntW-1:0]   mem_wdata;
  logic              mem_re;
  logic [EntW-1:0]   mem_rdata;

  logic [PidW:0]     quo_mul;
  logic [PidW-1:0]   slot_full;
  logic [IdxW-1:0]   head_slot;
  logic              load;
  res_t              res_calc;
  logic [CntW-1:0]   pkt_count_next;
  logic [CntW-1:0]   err_count_next;

  // Finish pid mod PID_SPACE from the queued quotient
  always_comb begin
    quo_mul   = (PidW + 1)'((PidW + 1)'(head.quo) * (PidW + 1)'(PID_SPACE));
    slot_full = PidW'(head.pid - quo_mul[PidW-1:0]);
    head_slot = slot_full[IdxW-1:0];
  end

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_READ) && head_valid;
  assign mem_re   = pop;
  assign load     = (state == ST_CHECK) && (!res_valid || !res_stall);

  // Memory write port: clearing pass, then checked packets
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_slot;
    mem_wdata = {1'b1, cur_cc};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (load && !cur_skip) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= table_mem[head_slot];
    end
  end

  // Check the packet against the stored counter
  always_comb begin
    res_calc                = '0;
    pkt_count_next          = pkt_count;
    err_count_next          = err_count;
    if (cur_skip) begin
      res_calc.skipped = 1'b1;
    end else begin
      pkt_count_next = (pkt_count == CntMax) ? pkt_count : pkt_count + 1'b1;
      if (mem_rdata[EntW-1]) begin
        res_calc.expected_cc = mem_rdata[CcW-1:0] + 1'b1;
        if (cur_cc != res_calc.expected_cc) begin
          res_calc.cc_error = 1'b1;
          err_count_next    = (err_count == CntMax) ? err_count : err_count + 1'b1;
          if (event_code != '0) begin
            res_calc.event_fire  = 1'b1;
            res_calc.event_value = event_code;
          end
        end
      end else begin
        res_calc.first_seen = 1'b1;
      end
    end
    res_calc.packet_total = pkt_count_next;
    res_calc.error_total  = err_count_next;
  end

  // Sequence: clear, read slot, check and write back
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IdxW'(PID_SPACE - 1)) state_next = ST_READ;
      end
      ST_READ: begin
        if (head_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (load) state_next = ST_READ;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      event_code <= '0;
      pkt_count  <= '0;
      err_count  <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (cfg.we && cfg.index == CfgEventCode) event_code <= cfg.data[EvW-1:0];
      if (load) begin
        pkt_count <= pkt_count_next;
        err_count <= err_count_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Latch the popped transaction and load results
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_slot <= head_slot;
      cur_cc   <= head.cont_count;
      cur_skip <= head.skip;
    end
    if (load) begin
      res <= res_calc;
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
      state != ST_CLEAR |=> state != ST_CLEAR)
    else $error("clearing pass restarted");
  a_err_le_pkt: assert property (@(posedge clk) disable iff (rst) err_count <= pkt_count)
    else $error("error count exceeds packet count");
  a_pkt_monotonic: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> pkt_count >= $past(pkt_count))
    else $error("packet count decreased");

endmodule

`default_nettype wire

FILE: src/ts_continuity_counter_monitor.sv
// Top level of the transport stream continuity counter monitor.
// Depends on tsccm_pkg, tsccm_front, tsccm_queue and tsccm_back.
//
//   channel  dir  handshake              payload
//   pkt      in   pkt_valid / pkt_stall  pkt (pid, cont_count)
//   res      out  res_valid / res_stall  res (one result per packet)
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// Each packet passes the checker's table memory read, then check and
// write-back through the single write port; the checker reads no new
// packet until the last is checked and loaded. The front end and a 4-entry
// queue accept packets while the checker or the result register is stalled.
// After reset a clearing pass over all PID_SPACE table entries wipes the
// seen bits, with pkt_stall high. Configuration writes take effect at once.
`default_nettype none

module ts_continuity_counter_monitor #(
  parameter int PID_SPACE = 8192
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pkt_valid,
  output logic                                  pkt_stall,
  input  wire tsccm_pkg::pkt_t                  pkt,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output tsccm_pkg::res_t                       res,
  input  wire logic                             cfg_we,
  input  wire logic [tsccm_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [tsccm_pkg::CfgDataW-1:0]   cfg_data
);
  import tsccm_pkg::*;

  cfg_wr_t  cfg;
  logic     q_push;
  q_entry_t q_entry;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head;
  logic     clearing;

  // Bundle configuration writes
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tsccm_front #(
    .PID_SPACE(PID_SPACE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt      (pkt),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  tsccm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  tsccm_back #(
    .PID_SPACE(PID_SPACE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ts_continuity_counter_monitor.sv
`timescale 1ns / 1ps
// Self-checking testbench for the transport stream continuity counter monitor.
// Depends on tsccm_pkg and ts_continuity_counter_monitor; keeps its own copy of
// the per-PID seen bits, last counters and totals to predict every result.

module tb_ts_continuity_counter_monitor;
  import tsccm_pkg::*;

  localparam int PidSpace   = 8192;
  localparam int CycleLimit = 400_000;
  localparam int PoolN      = 6;
  localparam int MaxPrinted = 50;

  logic                clk;
  logic                rst;
  logic                pkt_valid;
  logic                pkt_stall;
  pkt_t                pkt;
  logic                res_valid;
  logic                res_stall;
  res_t                res;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ts_continuity_counter_monitor #(.PID_SPACE(PidSpace)) u_top (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the monitor's registers and tables
  logic [PidW-1:0] filter_pid_q;
  logic [EvW-1:0]  event_code_q;
  bit              pid_seen [PidSpace];
  logic [CcW-1:0]  pid_last_cc [PidSpace];
  logic [CntW-1:0] packets_counted;
  logic [CntW-1:0] errors_counted;

  // Continuity verdicts still owed by the block, oldest first
  res_t verdict_q [$];

  int send_idle_pct;
  int stall_pct;
  int fail_count;
  int sent_count;
  int checked_count;
  int config_count;
  int cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdict_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [CntW-1:0] bump_sat(logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // Work out the verdict for one accepted packet and advance the shadow state
  function automatic res_t judge_packet(pkt_t p);
    res_t r;
    int   slot;
    r = '0;
    if (p.pid == NullPid || (filter_pid_q != NullPid && p.pid != filter_pid_q)) begin
      r.skipped = 1'b1;
    end else begin
      slot = int'(p.pid) % PidSpace;
      if (pid_seen[slot]) begin
        r.expected_cc = pid_last_cc[slot] + 1'b1;
        if (p.cont_count != r.expected_cc) begin
          r.cc_error     = 1'b1;
          errors_counted = bump_sat(errors_counted);
          if (event_code_q != '0) begin
            r.event_fire  = 1'b1;
            r.event_value = event_code_q;
          end
        end
      end else begin
        r.first_seen   = 1'b1;
        pid_seen[slot] = 1'b1;
      end
      pid_last_cc[slot] = p.cont_count;
      packets_counted   = bump_sat(packets_counted);
    end
    r.packet_total = packets_counted;
    r.error_total  = errors_counted;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxPrinted) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                checked_count, name, got, want));
  endtask

  // Compare each accepted result with the oldest verdict
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no packet outstanding");
      end else begin
        want = verdict_q.pop_front();
        check_field("skipped", 32'(res.skipped), 32'(want.skipped));
        check_field("first_seen", 32'(res.first_seen), 32'(want.first_seen));
        check_field("cc_error", 32'(res.cc_error), 32'(want.cc_error));
        check_field("expected_cc", 32'(res.expected_cc), 32'(want.expected_cc));
        check_field("event_fire", 32'(res.event_fire), 32'(want.event_fire));
        check_field("event_value", res.event_value, want.event_value);
        check_field("packet_total", res.packet_total, want.packet_total);
        check_field("error_total", res.error_total, want.error_total);
        checked_count++;
      end
    end
  end

  // Send one packet transaction, idling first at the current rate
  task automatic send_pkt(input logic [PidW-1:0] pid, input logic [CcW-1:0] cc);
    pkt_t p;
    p.pid        = pid;
    p.cont_count = cc;
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= p;
    do @(posedge clk); while (pkt_stall !== 1'b0);
    verdict_q.push_back(judge_packet(p));
    sent_count++;
  endtask

  // Drop valid and wait for every outstanding verdict to come back
  task automatic drain();
    pkt_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers once the block is idle
  task automatic configure(input logic [CfgDataW-1:0] filter_val,
                           input logic [CfgDataW-1:0] event_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CfgFilterPid;
    cfg_data  <= filter_val;
    @(posedge clk);
    filter_pid_q = filter_val[PidW-1:0];
    cfg_index <= CfgEventCode;
    cfg_data  <= event_val;
    @(posedge clk);
    event_code_q = event_val[EvW-1:0];
    cfg_we <= 1'b0;
    config_count++;
  endtask

  // Mostly in-order counters on a few PIDs, with errors, nulls and stray PIDs
  task automatic run_traffic(input int n);
    logic [PidW-1:0] pool [PoolN];
    logic [PidW-1:0] pid;
    logic [CcW-1:0]  cc;
    int              r;
    pool[0] = '0;
    pool[1] = NullPid - 1'b1;
    for (int i = 2; i < PoolN; i++) pool[i] = PidW'($urandom_range(NullPid - 1));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 5)
        pid = NullPid;
      else if (r < 15)
        pid = PidW'($urandom_range(NullPid - 1));
      else if (filter_pid_q != NullPid && r < 60)
        pid = filter_pid_q;
      else
        pid = pool[$urandom_range(PoolN - 1)];
      if (pid_seen[int'(pid) % PidSpace] && $urandom_range(99) < 85)
        cc = pid_last_cc[int'(pid) % PidSpace] + 1'b1;
      else
        cc = CcW'($urandom_range(15));
      send_pkt(pid, cc);
    end
  endtask

  // First packets, in-order and wrapping counters, errors with and without
  // events, null packets, filtering and register bits above the field width
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_pkt(13'd0, 4'd0);
    send_pkt(13'd0, 4'd1);
    send_pkt(13'd0, 4'd5);
    send_pkt(13'd8190, 4'd15);
    send_pkt(13'd8190, 4'd0);
    send_pkt(NullPid, 4'd7);
    send_pkt(13'd8190, 4'd0);
    send_pkt(13'd4096, 4'd8);
    send_pkt(13'd4095, 4'd15);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pkt(13'd0, 4'd5);
    send_pkt(13'd0, 4'd6);
    configure(32'h0000_1FFF, 32'h0000_0001);
    send_pkt(13'd0, 4'd15);
    configure(32'hFFFF_FFFE, 32'h8000_0000);
    send_pkt(13'd0, 4'd0);
    send_pkt(NullPid, 4'd3);
    send_pkt(13'd8190, 4'd1);
    send_pkt(13'd8190, 4'd9);
    configure(32'hFFFF_E000, 32'h0000_0000);
    send_pkt(13'd8190, 4'd10);
    send_pkt(13'd0, 4'd0);
    configure(32'h0000_1FFF, 32'h0000_0000);
    send_pkt(13'd4096, 4'd9);
    send_pkt(13'd4095, 4'd3);
  endtask

  task automatic test_line_rate();
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(360);
  endtask

  task automatic test_sparse_sender();
    send_idle_pct = 78;
    stall_pct     = 0;
    configure(32'h0000_0000, 32'h0000_0000);
    run_traffic(360);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 0;
    stall_pct     = 78;
    configure($urandom_range(NullPid - 1), $urandom());
    run_traffic(360);
  endtask

  task automatic test_mixed_idle();
    send_idle_pct = 33;
    stall_pct     = 33;
    configure(32'h0000_1FFF, 32'h0000_0001);
    run_traffic(370);
  endtask

  initial begin
    rst             = 1'b1;
    pkt_valid       = 1'b0;
    pkt             = '0;
    res_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CfgFilterPid;
    cfg_data        = '0;
    filter_pid_q    = NullPid;
    event_code_q    = '0;
    packets_counted = '0;
    errors_counted  = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    fail_count      = 0;
    sent_count      = 0;
    checked_count   = 0;
    config_count    = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_line_rate();
    test_sparse_sender();
    test_slow_receiver();
    test_mixed_idle();

    // Hold for stragglers after the last verdict
    drain();
    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

    $display("Sent %0d packets, checked %0d results (%0d counted, %0d continuity errors)",
             sent_count, checked_count, packets_counted, errors_counted);
    $display("Covered %0d register settings under four idle/stall profiles, %0d mismatches",
             config_count, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
